@@ rtl/tsfl_pkg.sv @@
`timescale 1ns / 1ps

package tsfl_pkg;

   // Pool geometry and field widths
   localparam int NUM_SLOTS = 64;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int CNT_W     = SLOT_W + 1;
   localparam int TOT_W     = CNT_W + 1;
   localparam int CYC_W     = 48;
   localparam int OCC_W     = 64;
   localparam int PROD_W    = CNT_W + CYC_W;
   localparam int SUM_W     = OCC_W + 1;
   localparam int FUNC_W    = 3;
   localparam int CTX_W     = 2;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_RESERVE   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_UNRESERVE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP       = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_PUSH      = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY     = 3'd4;

   // Counter selection codes
   localparam logic [CTX_W-1:0] CTX_NORMAL   = 2'd0;
   localparam logic [CTX_W-1:0] CTX_RESERVED = 2'd1;
   localparam logic [CTX_W-1:0] CTX_EXCL     = 2'd2;
   localparam logic [CTX_W-1:0] CTX_NONE     = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic reserve;
      logic unreserve;
      logic pop;
      logic push;
      logic stats;
      logic respond;
   } tsfl_cmd_type;

   // Datapath to controller: decoded outcome of the held request
   typedef struct packed {
      logic err;
      logic reserve_ok;
      logic unreserve_ok;
      logic pop_ok;
      logic push_ok;
   } tsfl_sts_type;

   // Slots in use for a given set of free counters
   function automatic logic [CNT_W-1:0] alloc_of(input logic [CNT_W-1:0] fn,
                                                 input logic [CNT_W-1:0] fr,
                                                 input logic             fe);
      logic [TOT_W-1:0] total;
      total = {1'b0, fn} + {1'b0, fr} + TOT_W'(fe);
      if (total >= TOT_W'(NUM_SLOTS)) begin
         return '0;
      end
      return CNT_W'(TOT_W'(NUM_SLOTS) - total);
   endfunction

endpackage

@@ rtl/tsfl_ctrl.sv @@
`timescale 1ns / 1ps

module tsfl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tsfl_pkg::tsfl_sts_type sts,
   output tsfl_pkg::tsfl_cmd_type cmd,
   output logic                  rsp_valid
);
   import tsfl_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff;

   // Sequencing: take request, then execute and respond
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.reserve   = sts.reserve_ok;
            cmd.unreserve = sts.unreserve_ok;
            cmd.pop       = sts.pop_ok;
            cmd.push      = sts.push_ok;
            cmd.stats     = sts.reserve_ok | sts.unreserve_ok | sts.pop_ok | sts.push_ok;
            cmd.respond   = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign busy      = (state_ff == ST_EXEC);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/tsfl_dp.sv @@
`timescale 1ns / 1ps

module tsfl_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  tsfl_pkg::tsfl_cmd_type         cmd,
   output tsfl_pkg::tsfl_sts_type         sts,
   input  logic [tsfl_pkg::FUNC_W-1:0]   req_func,
   input  logic [tsfl_pkg::CTX_W-1:0]    req_context_req,
   input  logic [tsfl_pkg::SLOT_W-1:0]   req_slot_in,
   input  logic [tsfl_pkg::CYC_W-1:0]    req_cycle_now,
   output logic [tsfl_pkg::SLOT_W-1:0]   rsp_slot_out,
   output logic                          rsp_granted,
   output logic                          rsp_error,
   output logic [tsfl_pkg::CNT_W-1:0]    rsp_free_count,
   output logic [tsfl_pkg::CNT_W-1:0]    rsp_allocated_now,
   output logic [tsfl_pkg::OCC_W-1:0]    rsp_occupancy_sum,
   output logic [tsfl_pkg::CNT_W-1:0]    rsp_peak_allocated
);
   import tsfl_pkg::*;

   // Held request
   logic [FUNC_W-1:0] func_ff;
   logic [CTX_W-1:0]  ctx_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [CYC_W-1:0]  cycle_ff;
   logic [CYC_W-1:0]  elapsed_ff;
   logic              used_rd_ff;

   // Free list and counters
   logic [CNT_W-1:0]     link_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] link_vld_ff, link_vld_in;
   logic [CNT_W-1:0]     link_rd_ff;
   logic                 link_rd_vld_ff;
   logic [NUM_SLOTS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     fn_ff, fn_in;
   logic [CNT_W-1:0]     fr_ff, fr_in;
   logic                 fe_ff, fe_in;

   // Statistics
   logic [CYC_W-1:0] last_ff, last_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] peak_ff, peak_in;

   // Response registers
   logic [SLOT_W-1:0] slot_out_ff;
   logic              granted_ff;
   logic              error_ff;
   logic [CNT_W-1:0]  free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]  alloc_out_ff;

   logic [SLOT_W-1:0] head_idx;
   logic [CNT_W-1:0]  link_next;
   logic [CNT_W-1:0]  cnt_sel;
   logic [CNT_W-1:0]  alloc_cur;
   logic [TOT_W-1:0]  total_free;
   logic              ctx_ok;
   logic              head_ok;
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  sum;

   assign head_idx = head_ff[SLOT_W-1:0];
   // Entries never written give the reset link, index plus one
   assign link_next = link_rd_vld_ff ? link_rd_ff : ({1'b0, head_idx} + CNT_W'(1));
   assign alloc_cur = alloc_of(fn_ff, fr_ff, fe_ff);
   assign total_free = {1'b0, fn_ff} + {1'b0, fr_ff} + TOT_W'(fe_ff);
   assign ctx_ok = (ctx_ff != CTX_NONE);
   assign head_ok = (head_ff < CNT_W'(NUM_SLOTS));

   // Counter named by the request
   always_comb begin
      case (ctx_ff)
         CTX_NORMAL:   cnt_sel = fn_ff;
         CTX_RESERVED: cnt_sel = fr_ff;
         CTX_EXCL:     cnt_sel = CNT_W'(fe_ff);
         default:      cnt_sel = '0;
      endcase
   end

   // Request decode
   always_comb begin
      sts = '0;
      case (func_ff)
         FUNC_RESERVE: begin
            sts.err        = (fn_ff == '0);
            sts.reserve_ok = (fn_ff != '0);
         end
         FUNC_UNRESERVE: begin
            sts.err          = (fr_ff == '0);
            sts.unreserve_ok = (fr_ff != '0);
         end
         FUNC_POP: begin
            sts.err    = !ctx_ok;
            sts.pop_ok = ctx_ok && (cnt_sel != '0) && head_ok;
         end
         FUNC_PUSH: begin
            sts.err = !ctx_ok || !used_rd_ff || ((ctx_ff == CTX_EXCL) && fe_ff) ||
                      (total_free >= TOT_W'(NUM_SLOTS));
            sts.push_ok = !sts.err;
         end
         FUNC_QUERY: begin
            sts.err = !ctx_ok;
         end
         default: begin
            sts.err = 1'b1;
         end
      endcase
   end

   // Occupancy integral: allocated count before the change times elapsed cycles
   assign prod = PROD_W'(alloc_cur) * PROD_W'(elapsed_ff);
   assign sum  = {1'b0, occ_ff} + SUM_W'(prod);

   // Next state of list, counters and statistics
   always_comb begin
      fn_in       = fn_ff;
      fr_in       = fr_ff;
      fe_in       = fe_ff;
      head_in     = head_ff;
      used_in     = used_ff;
      link_vld_in = link_vld_ff;
      last_in     = last_ff;
      occ_in      = occ_ff;
      peak_in     = peak_ff;
      if (cmd.reserve) begin
         fn_in = fn_ff - CNT_W'(1);
         fr_in = fr_ff + CNT_W'(1);
      end
      if (cmd.unreserve) begin
         fn_in = fn_ff + CNT_W'(1);
         fr_in = fr_ff - CNT_W'(1);
      end
      if (cmd.pop) begin
         head_in           = link_next;
         used_in[head_idx] = 1'b1;
         case (ctx_ff)
            CTX_NORMAL:   fn_in = fn_ff - CNT_W'(1);
            CTX_RESERVED: fr_in = fr_ff - CNT_W'(1);
            CTX_EXCL:     fe_in = 1'b0;
            default:      fe_in = fe_ff;
         endcase
      end
      if (cmd.push) begin
         head_in              = {1'b0, slot_ff};
         used_in[slot_ff]     = 1'b0;
         link_vld_in[slot_ff] = 1'b1;
         case (ctx_ff)
            CTX_NORMAL:   fn_in = fn_ff + CNT_W'(1);
            CTX_RESERVED: fr_in = fr_ff + CNT_W'(1);
            CTX_EXCL:     fe_in = 1'b1;
            default:      fe_in = fe_ff;
         endcase
      end
      if (cmd.stats) begin
         last_in = cycle_ff;
         occ_in  = sum[OCC_W] ? '1 : sum[OCC_W-1:0];
         peak_in = (alloc_cur > peak_ff) ? alloc_cur : peak_ff;
      end
   end

   // Free count after the step
   always_comb begin
      case (ctx_ff)
         CTX_NORMAL:   free_cnt_in = fn_in;
         CTX_RESERVED: free_cnt_in = fr_in;
         CTX_EXCL:     free_cnt_in = CNT_W'(fe_in);
         default:      free_cnt_in = '0;
      endcase
   end

   // Link memory: written by push, head entry read on capture
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         link_mem[slot_ff] <= head_ff;
      end
      if (cmd.capture) begin
         link_rd_ff <= link_mem[head_idx];
      end
   end

   // Request capture and response payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req_func;
         ctx_ff     <= req_context_req;
         slot_ff    <= req_slot_in;
         cycle_ff   <= req_cycle_now;
         elapsed_ff <= req_cycle_now - last_ff;
         // in-use flag of the pushed slot, stable until execute
         used_rd_ff <= used_ff[req_slot_in];
      end
      if (cmd.respond) begin
         slot_out_ff  <= cmd.pop ? head_idx : '0;
         granted_ff   <= cmd.pop;
         error_ff     <= sts.err;
         free_cnt_ff  <= free_cnt_in;
         alloc_out_ff <= alloc_of(fn_in, fr_in, fe_in);
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff    <= '0;
         link_rd_vld_ff <= 1'b0;
         used_ff        <= '0;
         head_ff        <= '0;
         fn_ff          <= CNT_W'(NUM_SLOTS - 1);
         fr_ff          <= '0;
         fe_ff          <= 1'b1;
         last_ff        <= '0;
         occ_ff         <= '0;
         peak_ff        <= '0;
      end else begin
         link_vld_ff <= link_vld_in;
         if (cmd.capture) begin
            link_rd_vld_ff <= link_vld_ff[head_idx];
         end
         used_ff <= used_in;
         head_ff <= head_in;
         fn_ff   <= fn_in;
         fr_ff   <= fr_in;
         fe_ff   <= fe_in;
         last_ff <= last_in;
         occ_ff  <= occ_in;
         peak_ff <= peak_in;
      end
   end

   assign rsp_slot_out       = slot_out_ff;
   assign rsp_granted        = granted_ff;
   assign rsp_error          = error_ff;
   assign rsp_free_count     = free_cnt_ff;
   assign rsp_allocated_now  = alloc_out_ff;
   assign rsp_occupancy_sum  = occ_ff;
   assign rsp_peak_allocated = peak_ff;

endmodule

@@ rtl/thread_slot_free_list_top.sv @@
`timescale 1ns / 1ps

// Channel   Ports                                     Handshake
// request   req_func, req_context_req, req_slot_in,   taken when start && !busy
//           req_cycle_now
// response  rsp_slot_out, rsp_granted, rsp_error,     one cycle, marked by rsp_valid
//           rsp_free_count, rsp_allocated_now,
//           rsp_occupancy_sum, rsp_peak_allocated
//
// For each request, the capture cycle reads the link of the head slot
// from the link memory, the next cycle decodes, updates list, counters and
// statistics and registers the response. rsp_valid is high in the cycle after
// that, and a new request may be taken in that same cycle.
// Synchronous active-high reset; the state is ready for requests right after it.
// The receiver cannot stall; busy is high only during the execute cycle.

module thread_slot_free_list_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tsfl_pkg::FUNC_W-1:0]   req_func,
   input  logic [tsfl_pkg::CTX_W-1:0]    req_context_req,
   input  logic [tsfl_pkg::SLOT_W-1:0]   req_slot_in,
   input  logic [tsfl_pkg::CYC_W-1:0]    req_cycle_now,
   output logic                          rsp_valid,
   output logic [tsfl_pkg::SLOT_W-1:0]   rsp_slot_out,
   output logic                          rsp_granted,
   output logic                          rsp_error,
   output logic [tsfl_pkg::CNT_W-1:0]    rsp_free_count,
   output logic [tsfl_pkg::CNT_W-1:0]    rsp_allocated_now,
   output logic [tsfl_pkg::OCC_W-1:0]    rsp_occupancy_sum,
   output logic [tsfl_pkg::CNT_W-1:0]    rsp_peak_allocated
);
   import tsfl_pkg::*;

   tsfl_cmd_type cmd;
   tsfl_sts_type sts;

   // Sequencer
   tsfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .sts       (sts),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // Free list, counters and statistics
   tsfl_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_func),
      .req_context_req    (req_context_req),
      .req_slot_in        (req_slot_in),
      .req_cycle_now      (req_cycle_now),
      .rsp_slot_out       (rsp_slot_out),
      .rsp_granted        (rsp_granted),
      .rsp_error          (rsp_error),
      .rsp_free_count     (rsp_free_count),
      .rsp_allocated_now  (rsp_allocated_now),
      .rsp_occupancy_sum  (rsp_occupancy_sum),
      .rsp_peak_allocated (rsp_peak_allocated)
   );

endmodule

@@ rtl/tsfl_checker.sv @@
`timescale 1ns / 1ps

module tsfl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic                        rsp_granted,
   input logic                        rsp_error,
   input logic [tsfl_pkg::CNT_W-1:0]  rsp_allocated_now,
   input logic [tsfl_pkg::CNT_W-1:0]  rsp_peak_allocated
);
   import tsfl_pkg::*;

   // A taken request is answered after capture and execute
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("request not answered on time");

   // Execute lasts a single cycle
   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held too long");

   // Each response is a single cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response repeated");

   // A grant is never an error
   a_grant_no_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted) |-> !rsp_error)
      else $error("granted with error");

   // Allocation and peak stay within the pool
   a_alloc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_allocated_now <= CNT_W'(NUM_SLOTS)) &&
                    (rsp_peak_allocated <= CNT_W'(NUM_SLOTS)))
      else $error("allocation out of range");

endmodule

bind thread_slot_free_list_top tsfl_checker u_tsfl_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_granted        (rsp_granted),
   .rsp_error          (rsp_error),
   .rsp_allocated_now  (rsp_allocated_now),
   .rsp_peak_allocated (rsp_peak_allocated)
);
